// ----- src/image_upscale_bilinear_x2_x3_defines.svh -----
// Assertion macros shared by the upscaler RTL.
`ifndef IMAGE_UPSCALE_BILINEAR_X2_X3_DEFINES_SVH
`define IMAGE_UPSCALE_BILINEAR_X2_X3_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define IUB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("upscaler assertion failed");

// The condition must never be true outside reset.
`define IUB_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("upscaler forbidden condition seen");

`else

`define IUB_ASSERT(lbl, clk, rstn, prop)
`define IUB_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- src/iub_pkg.sv -----
package iub_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Counter widths follow the largest frame.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [1:0]            RST_SCALE  = 2'd2;
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;

    localparam logic [CFG_DATA_W-1:0] MIN_SIZE   = 11'd2;
    localparam logic [CFG_DATA_W-1:0] MAX_W_SIZE = CFG_DATA_W'(MAX_WIDTH);
    localparam logic [CFG_DATA_W-1:0] MAX_H_SIZE = CFG_DATA_W'(MAX_HEIGHT);

    // Reciprocal of three in 9 fractional bits; exact for magnitudes up to 255.
    localparam logic [16:0] RECIP3 = 17'd171;

    // One source pixel and its cell, held while its output block is emitted.
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   upleft;
        logic [COORD_W-1:0] row_base;
        logic [COORD_W-1:0] col_base;
        logic [1:0]         dy_max;
        logic [1:0]         dx_max;
        logic               s3;
    } item_t;

    // Value at offset k of s (s is 3 when s3 is set, else 2) from a toward b.
    function automatic logic [PIX_W-1:0] lerp_step(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [1:0]       k,
                                                   input logic             s3);
        logic [8:0]       diff;
        logic             neg;
        logic [7:0]       mag;
        logic [16:0]      prod;
        logic [7:0]       qm;
        logic [8:0]       stp;
        logic [8:0]       avg;
        logic [PIX_W-1:0] res;
        diff = {1'b0, b} - {1'b0, a};
        neg  = diff[8];
        mag  = neg ? 8'(-diff) : diff[7:0];
        prod = 17'(mag) * RECIP3;
        qm   = prod[16:9];
        stp  = (k == 2'd2) ? {qm, 1'b0} : {1'b0, qm};
        avg  = ({1'b0, a} + {1'b0, b}) >> 1;
        if (s3) begin
            if (k == 2'd3) begin
                res = b;
            end else if (neg) begin
                res = a - stp[7:0];
            end else begin
                res = a + stp[7:0];
            end
        end else begin
            if (k[1]) begin
                res = b;
            end else begin
                res = avg[7:0];
            end
        end
        return res;
    endfunction

endpackage

// ----- src/image_upscale_bilinear_x2_x3.sv -----
// Bilinear x2/x3 image upscaler. Source pixels enter in raster order, one
// word per s_ handshake; each word produces the S by S block of output
// pixels (S = 2 or 3) whose lower-right corner is that source pixel, cut to
// one row and/or one column on the first source row and column, so a word
// yields 1, S or S*S output words, each tagged with its output row and
// column and with m_last on the final one. The output image is
// (W-1)*S+1 by (H-1)*S+1. The output port moves one word per cycle while
// m_ready allows, so an input word occupies the block until its last output
// word goes out; the next input word is accepted in the same cycle that the
// last output word of its predecessor loads into the output register. The
// previous source row lives in a 1024-entry single-port RAM that is read and
// written at the same column when a word is accepted; it needs no clearing
// pass because row 0 of each frame fills it before it is read. Configuration
// is written through cfg_wr_en/cfg_addr/cfg_wdata while the block is idle;
// any write, even to an unused index, restarts the frame at pixel (0, 0).
// A scale factor other than 3 acts as 2, and width and height saturate
// into 2..1024.
module image_upscale_bilinear_x2_x3 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [iub_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [iub_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [iub_pkg::PIX_W-1:0]          s_pixel,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [iub_pkg::COORD_W-1:0]        m_out_row,
    output logic [iub_pkg::COORD_W-1:0]        m_out_col,
    output logic [iub_pkg::PIX_W-1:0]          m_value,
    output logic                               m_last
);
    import iub_pkg::*;
    `include "image_upscale_bilinear_x2_x3_defines.svh"

    // Configuration registers.
    logic [1:0]            scale_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Frame position of the next source pixel.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Previous source row, and the word read from it for the current pixel.
    logic [PIX_W-1:0] row_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_reg;
    logic [PIX_W-1:0] prev_pix_reg;

    // Item being emitted and its position inside the output block.
    item_t      item_reg;
    item_t      item_next;
    logic       busy_reg;
    logic [1:0] dy_reg;
    logic [1:0] dx_reg;
    logic [1:0] dy_next;
    logic [1:0] dx_next;

    // Output register.
    logic               m_valid_reg;
    logic [COORD_W-1:0] m_row_reg;
    logic [COORD_W-1:0] m_col_reg;
    logic [PIX_W-1:0]   m_value_reg;
    logic               m_last_reg;

    logic                  s3;
    logic [CFG_DATA_W-1:0] w_eff;
    logic [CFG_DATA_W-1:0] h_eff;
    logic                  row_end;
    logic                  frame_end;
    logic                  in_acc;
    logic                  out_free;
    logic                  emit;
    logic                  last_now;
    logic [COORD_W-1:0]    row_x2;
    logic [COORD_W-1:0]    col_x2;
    logic [1:0]            kx;
    logic [1:0]            ky;
    logic [PIX_W-1:0]      top_val;
    logic [PIX_W-1:0]      bot_val;
    logic [PIX_W-1:0]      pix_val;

    // Effective factor and frame size.
    always_comb begin
        s3 = (scale_reg == 2'd3);
        if (width_reg < MIN_SIZE) begin
            w_eff = MIN_SIZE;
        end else if (width_reg > MAX_W_SIZE) begin
            w_eff = MAX_W_SIZE;
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < MIN_SIZE) begin
            h_eff = MIN_SIZE;
        end else if (height_reg > MAX_H_SIZE) begin
            h_eff = MAX_H_SIZE;
        end else begin
            h_eff = height_reg;
        end
        row_end   = (CFG_DATA_W'(col_reg) + 11'd1) >= w_eff;
        frame_end = (CFG_DATA_W'(row_reg) + 11'd1) >= h_eff;
    end

    // Handshake. The item stage frees up in the cycle its last word leaves.
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        emit     = busy_reg && out_free;
        last_now = (dx_reg == 2'd0) && (dy_reg == 2'd0);
        s_ready  = !busy_reg || (out_free && last_now);
        in_acc   = s_valid && s_ready;
    end

    // Item capture. The upper-left corner is the row word read for the
    // previous pixel; at column 0 neither left corner is used.
    always_comb begin
        row_x2             = {1'b0, row_reg, 1'b0};
        col_x2             = {1'b0, col_reg, 1'b0};
        item_next.pix      = s_pixel;
        item_next.left     = prev_pix_reg;
        item_next.upleft   = up_reg;
        item_next.row_base = s3 ? (row_x2 + COORD_W'(row_reg)) : row_x2;
        item_next.col_base = s3 ? (col_x2 + COORD_W'(col_reg)) : col_x2;
        item_next.dy_max   = (row_reg == '0) ? 2'd0 : (s3 ? 2'd2 : 2'd1);
        item_next.dx_max   = (col_reg == '0) ? 2'd0 : (s3 ? 2'd2 : 2'd1);
        item_next.s3       = s3;
    end

    // Walk the block in row-major order, counting offsets down to zero.
    always_comb begin
        if (dx_reg != 2'd0) begin
            dx_next = dx_reg - 2'd1;
            dy_next = dy_reg;
        end else begin
            dx_next = item_reg.dx_max;
            dy_next = dy_reg - 2'd1;
        end
    end

    // Interpolate along both source rows, then down the column.
    always_comb begin
        kx      = (item_reg.s3 ? 2'd3 : 2'd2) - dx_reg;
        ky      = (item_reg.s3 ? 2'd3 : 2'd2) - dy_reg;
        top_val = lerp_step(item_reg.upleft, up_reg, kx, item_reg.s3);
        bot_val = lerp_step(item_reg.left, item_reg.pix, kx, item_reg.s3);
        pix_val = lerp_step(top_val, bot_val, ky, item_reg.s3);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= RST_SCALE;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            col_reg     <= '0;
            row_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                busy_reg <= 1'b1;
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end else if (emit && last_now) begin
                busy_reg <= 1'b0;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // A write of any index restarts the frame.
            if (cfg_wr_en) begin
                col_reg <= '0;
                row_reg <= '0;
                case (cfg_addr)
                    CFG_SCALE_FACTOR: scale_reg  <= cfg_wdata[1:0];
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    // Block offsets and payload.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            item_reg     <= item_next;
            dy_reg       <= item_next.dy_max;
            dx_reg       <= item_next.dx_max;
            prev_pix_reg <= s_pixel;
        end else if (emit && !last_now) begin
            dy_reg <= dy_next;
            dx_reg <= dx_next;
        end
        if (emit) begin
            m_row_reg   <= item_reg.row_base - COORD_W'(dy_reg);
            m_col_reg   <= item_reg.col_base - COORD_W'(dx_reg);
            m_value_reg <= pix_val;
            m_last_reg  <= last_now;
        end
    end

    // Row store: read-first single port, addressed by the current column.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            up_reg           <= row_mem[col_reg];
            row_mem[col_reg] <= s_pixel;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;
    assign m_value   = m_value_reg;
    assign m_last    = m_last_reg;

    // A new word may only replace a busy item as its last word goes out.
    `IUB_ASSERT(a_accept_on_last, aclk, aresetn, (in_acc && busy_reg) |-> (emit && last_now))
    // Block offsets never run past the extent captured for the item.
    `IUB_ASSERT(a_offsets_bounded, aclk, aresetn,
        busy_reg |-> (dx_reg <= item_reg.dx_max && dy_reg <= item_reg.dy_max))
    // With nothing in flight, a taken output word leaves the port empty.
    `IUB_ASSERT(a_drain_empty, aclk, aresetn,
        (m_valid_reg && m_ready && !busy_reg) |=> !m_valid_reg)
    // An output word that is not the last keeps the item stage occupied.
    `IUB_ASSERT_NEVER(a_orphan_word, aclk, aresetn, m_valid_reg && !m_last_reg && !busy_reg)

endmodule

// ----- dv/tb_image_upscale_bilinear_x2_x3.sv -----
module tb_image_upscale_bilinear_x2_x3;
    timeunit 1ns;
    timeprecision 1ps;

    import iub_pkg::*;

    // Writes to this index change no register but still restart the frame.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    // Number of source words in the random part, before the closing frame.
    localparam int RANDOM_WORDS = 380;

    // Size of the closing frame, sent at x3 without idling.
    localparam int LAST_W = 16;
    localparam int LAST_H = 3;

    // Output words after which the receiver stops taking words for a long while.
    localparam int HOLD_AT_A = 150;
    localparam int HOLD_AT_B = 1200;
    localparam int HOLD_AT_C = 3000;

    // One output word as the block presents it.
    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   value;
        logic               last;
    } out_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COORD_W-1:0]    m_out_row;
    logic [COORD_W-1:0]    m_out_col;
    logic [PIX_W-1:0]      m_value;
    logic                  m_last;

    image_upscale_bilinear_x2_x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_value   (m_value),
        .m_last    (m_last)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Source pixels waiting to be offered, and output words still owed by the
    // block in the order it must produce them.
    logic [PIX_W-1:0] pixel_q[$];
    out_word_t        expected_words[$];

    // Shadow of the block: its registers as last written, the previous source
    // row, the two held neighbours of the current pixel and the raster position.
    logic [1:0]            scale_reg = RST_SCALE;
    logic [CFG_DATA_W-1:0] width_reg = RST_WIDTH;
    logic [CFG_DATA_W-1:0] height_reg = RST_HEIGHT;
    logic [PIX_W-1:0]      line_buf[MAX_WIDTH];
    logic [PIX_W-1:0]      left_px = '0;
    logic [PIX_W-1:0]      upleft_px = '0;
    int                    col_pos = 0;
    int                    row_pos = 0;

    // Idling switches, changed per phase, and bookkeeping for the checker.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;
    int tx_gap = 0;
    int rx_hold = 0;
    int words_seen = 0;
    int bad_words = 0;
    logic [PIX_W-1:0] prev_pix = '0;

    // Width and height registers saturate into 2..limit inside the block.
    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v < 2) return 2;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Point k of s on the way from a to b. At x2 the midpoint is the floor of
    // the mean; at x3 the step is a third of the difference rounded toward
    // zero, so a falling step that does not divide by three lands above a floored one.
    function automatic logic [PIX_W-1:0] blend_toward(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b,
                                                      input int k, input int s);
        int diff;
        if (k >= s) return b;
        if (s == 2) return PIX_W'((int'(a) + int'(b)) >> 1);
        diff = int'(b) - int'(a);
        return PIX_W'(int'(a) + (diff / 3) * k);
    endfunction

    // Works out the output block that one accepted source pixel completes and
    // queues it, then advances the shadow state. The block covers the cell to
    // the upper left of the pixel; on the first source row only its bottom row
    // exists and on the first column only its right column.
    task automatic upscale_pixel(input logic [PIX_W-1:0] pix);
        int s;
        int w;
        int h;
        int c;
        int r;
        int dy;
        int dx;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] above_left;
        logic [PIX_W-1:0] lf_px;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] bottom;
        out_word_t        word;
        s = (scale_reg == 2'd3) ? 3 : 2;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        above = line_buf[c];
        above_left = upleft_px;
        lf_px = left_px;
        for (dy = (r == 0) ? 0 : s - 1; dy >= 0; dy--) begin
            for (dx = (c == 0) ? 0 : s - 1; dx >= 0; dx--) begin
                top = blend_toward(above_left, above, s - dx, s);
                bottom = blend_toward(lf_px, pix, s - dx, s);
                word.value = blend_toward(top, bottom, s - dy, s);
                word.row = COORD_W'(r * s - dy);
                word.col = COORD_W'(c * s - dx);
                word.last = (dy == 0 && dx == 0);
                expected_words.push_back(word);
            end
        end
        line_buf[c] = pix;
        upleft_px = above;
        left_px = pix;
        if (c + 1 >= w) begin
            // End of a source row: the neighbours start from zero again, and
            // after the last row the frame wraps to its first pixel.
            col_pos = 0;
            left_px = '0;
            upleft_px = '0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel content by style: uniform noise, hard black and white edges,
    // or a slow walk that keeps neighbouring differences small.
    function automatic logic [PIX_W-1:0] pick_pixel(input int style);
        int walk;
        case (style)
            0: prev_pix = PIX_W'($urandom);
            1: prev_pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: begin
                walk = int'(prev_pix) + $urandom_range(0, 40) - 20;
                prev_pix = (walk < 0) ? 8'd0 : (walk > 255) ? 8'd255 : PIX_W'(walk);
            end
        endcase
        return prev_pix;
    endfunction

    // Driver: offers the next queued pixel whenever the channel is free and
    // the current gap has run out. The pixel is predicted at the edge that
    // accepts it, so the shadow state follows the block word for word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                upscale_pixel(s_pixel);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_q.pop_front();
                    if (tx_idle) begin
                        tx_gap = pick_gap();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted output word against the oldest one owed,
    // and throttles m_ready. A few times in the run it stops taking words while
    // the sender keeps offering, which backs the block up until it refuses input.
    always @(posedge aclk) begin
        out_word_t want;
        bit        long_hold;
        long_hold = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                long_hold = (words_seen == HOLD_AT_A || words_seen == HOLD_AT_B ||
                             words_seen == HOLD_AT_C);
                if (expected_words.size() == 0) begin
                    bad_words++;
                    $display("%0t: unexpected word row %0d col %0d value %0d last %0d",
                             $time, m_out_row, m_out_col, m_value, m_last);
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_row !== want.row || m_out_col !== want.col ||
                        m_value !== want.value || m_last !== want.last) begin
                        bad_words++;
                        $display("%0t: expected row %0d col %0d value %0d last %0d,",
                                 $time, want.row, want.col, want.value, want.last,
                                 " got row %0d col %0d value %0d last %0d",
                                 m_out_row, m_out_col, m_value, m_last);
                    end
                end
            end
            if (hold_req) begin
                long_hold = 1'b1;
                hold_req = 1'b0;
            end
            if (long_hold) begin
                m_ready <= 1'b0;
                rx_hold = $urandom_range(150, 250);
            end else if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle) begin
                    rx_hold = pick_gap();
                end
            end
        end
    end

    // One register write per clock; the shadow takes the value at once since
    // nothing is in flight. Any write restarts the frame but keeps the line.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SCALE_FACTOR: scale_reg = val[1:0];
            CFG_IMAGE_WIDTH:  width_reg = val;
            CFG_IMAGE_HEIGHT: height_reg = val;
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
        left_px = '0;
        upleft_px = '0;
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Blocks until every queued pixel has been taken and every owed word seen.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (pixel_q.size() > 0 || s_valid || expected_words.size() > 0);
    endtask

    task automatic queue_pixels(input int count, input int style);
        repeat (count) pixel_q.push_back(pick_pixel(style));
    endtask

    initial begin
        logic [PIX_W-1:0] row0_copy[3];
        logic [PIX_W-1:0] x3_frame[11];
        logic [PIX_W-1:0] min_frame[5];
        int random_done;
        int phase_no;
        int frame_px;
        int count;
        int split;
        int style;
        int roll;
        logic [CFG_DATA_W-1:0] scale_val;

        row0_copy = '{8'd0, 8'd255, 8'd128};
        x3_frame = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                     8'd100, 8'd1, 8'd254, 8'd7, 8'd200};
        min_frame = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd90};
        foreach (line_buf[i]) line_buf[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. First the reset settings: a few pixels of row 0,
        // which come out as a copy and plain x2 midpoints.
        foreach (row0_copy[i]) pixel_q.push_back(row0_copy[i]);
        wait_idle();

        // A 3x3 frame at x3 with full-swing edges, rising and falling steps
        // that do not divide by three, then the wrap into the next frame.
        write_reg(CFG_SCALE_FACTOR, 11'd3);
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        end_writes();
        foreach (x3_frame[i]) pixel_q.push_back(x3_frame[i]);
        wait_idle();

        // An illegal factor falls back to x2, and sizes below two saturate,
        // giving the smallest 2x2 frame; the last pixel starts a new frame.
        write_reg(CFG_SCALE_FACTOR, 11'h7FC);
        write_reg(CFG_IMAGE_WIDTH, 11'd1);
        write_reg(CFG_IMAGE_HEIGHT, 11'd0);
        end_writes();
        foreach (min_frame[i]) pixel_q.push_back(min_frame[i]);
        wait_idle();

        // Random phases: small frames at varied settings. Many phases send
        // whole frames, some break off mid-frame, and some stop part of the way to
        // let the block drain completely before carrying on.
        random_done = 0;
        phase_no = 0;
        while (random_done < RANDOM_WORDS) begin
            wait_idle();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                roll = $urandom_range(0, 9);
                scale_val = (roll < 4) ? 11'd3 : (roll < 8) ? 11'd2 :
                            (roll == 8) ? CFG_DATA_W'($urandom_range(0, 1)) :
                            CFG_DATA_W'($urandom);
                write_reg(CFG_SCALE_FACTOR, scale_val);
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 6) == 0) ?
                          CFG_DATA_W'($urandom_range(0, 1)) :
                          CFG_DATA_W'($urandom_range(2, 9)));
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 6) == 0) ?
                          CFG_DATA_W'($urandom_range(0, 1)) :
                          CFG_DATA_W'($urandom_range(2, 6)));
            end
            if ($urandom_range(0, 4) == 0) begin
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            end_writes();

            frame_px = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
            count = frame_px * $urandom_range(0, 2);
            if (count == 0 || $urandom_range(0, 3) == 0) begin
                count += $urandom_range(1, frame_px);
            end
            style = $urandom_range(0, 2);
            if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
                split = $urandom_range(1, count);
                queue_pixels(split, style);
                wait_idle();
                queue_pixels(count - split, style);
            end else begin
                queue_pixels(count, style);
            end
            random_done += count;
            phase_no++;
        end

        // A whole frame at x3 sent back to back with no idling. The receiver
        // holds off for a long stretch right away, so the block fills up and
        // refuses input until the receiver resumes.
        wait_idle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(CFG_SCALE_FACTOR, 11'd3);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(LAST_W));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(LAST_H));
        end_writes();
        queue_pixels(LAST_W * LAST_H, 0);
        hold_req = 1'b1;

        wait_idle();
        // Give the block time to show any stray word before the verdict.
        repeat (20) @(posedge aclk);
        if (bad_words == 0 && expected_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
